### src/ddsf_pkg.sv
package ddsf_pkg;

	localparam int MAX_DIGITS  = 17;
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W       = $clog2(MAX_DIGITS);
	// one job per buffer bank, two banks
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PLAIN_MIN_DEC   = -3;
	localparam int TRAIL_LIMIT     = 5;
	localparam int TRAIL_LIMIT_KPZ = 3;
	localparam int EXP_MAX         = 999;
	localparam int DEC_HUNDRED     = 100;
	localparam int DEC_TEN         = 10;

	localparam logic [7:0] CH_MINUS        = 8'h2D;
	localparam logic [7:0] CH_PLUS         = 8'h2B;
	localparam logic [7:0] CH_POINT        = 8'h2E;
	localparam logic [7:0] CH_ZERO         = 8'h30;
	localparam logic [7:0] CH_NINE         = 8'h39;
	localparam logic [7:0] CH_E_UPPER      = 8'h45;
	localparam logic [7:0] LETTER_CASE_BIT = 8'h20;
	localparam logic [7:0] FMT_R           = 8'h72;
	localparam logic [7:0] FMT_N           = 8'h6E;
	localparam logic [7:0] FMT_G           = 8'h67;

	typedef enum logic [2:0] {
		MODE_PASS,
		MODE_EXP_R,
		MODE_EXP_N,
		MODE_EXP_E,
		MODE_PLAIN_NEG,
		MODE_PLAIN_MID,
		MODE_PLAIN_INT
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIGN,
		ST_LEAD_ZERO,
		ST_LEAD_POINT,
		ST_ZEROS_PRE,
		ST_MANT,
		ST_MID_POINT,
		ST_ZEROS_POST,
		ST_TAIL_POINT,
		ST_TAIL_ZERO,
		ST_EXP_LETTER,
		ST_EXP_SIGN,
		ST_EXP_D2,
		ST_EXP_D1,
		ST_EXP_D0
	} seq_state_t;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] len;
		mode_t            mode;
		logic             neg;
		logic             lower;
		logic             kpz;
		logic             has_point;
		logic [CNT_W-1:0] point_at;
		logic [2:0]       zeros;
		logic             exp_neg;
		logic [3:0]       exp_hund;
		logic [6:0]       exp_rem;
	} job_t;

	typedef struct packed {
		logic             en;
		logic             bank;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} buf_wr_t;

endpackage

### src/ddsf_front.sv
module ddsf_front import ddsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [7:0]        char_in,
	input  logic              last_in,
	input  logic              negative,
	input  logic signed [10:0] point_position,
	input  logic [7:0]        format_letter,
	input  logic              cfg_write_en,
	input  logic              cfg_write_data,
	input  logic [QCNT_W-1:0] q_count,
	output logic              push,
	output job_t              push_job,
	output buf_wr_t           buf_wr
);

	logic             kpz_q;
	logic [CNT_W-1:0] count_q;
	logic             wbank_q;
	logic             lead_q;

	logic              valid_s1;
	logic signed [10:0] dec_s1;
	logic [CNT_W-1:0]  len_s1;
	logic [7:0]        fmt_s1;
	logic              neg_s1;
	logic              lead_s1;
	logic              kpz_s1;
	logic              bank_s1;

	logic [QCNT_W:0]  busy;
	logic             accept;
	logic             char_is_digit;
	logic             has_room;
	logic [CNT_W-1:0] len_now;
	logic             lead_now;

	logic signed [11:0] dec12;
	logic signed [11:0] len12;
	logic signed [11:0] over;
	logic signed [11:0] limit;
	logic signed [11:0] neg_dec;
	logic signed [11:0] e12;
	logic [11:0]        mag12;
	logic [9:0]         sat10;
	logic [9:0]         rem10;
	logic [3:0]         hund;
	logic [7:0]         fmt_lc;
	logic               plain;
	mode_t              mode;

	// banks held by jobs still waiting or printing
	assign busy       = {1'b0, q_count} + (QCNT_W+1)'(valid_s1);
	assign item_stall = busy >= (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept     = item_valid && !item_stall;

	assign char_is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign has_room      = count_q < CNT_W'(MAX_DIGITS);
	assign len_now       = has_room ? count_q + CNT_W'(1) : count_q;
	assign lead_now      = (count_q == '0) ? char_is_digit : lead_q;

	assign buf_wr.en   = accept && has_room;
	assign buf_wr.bank = wbank_q;
	assign buf_wr.addr = count_q[IDX_W-1:0];
	assign buf_wr.data = char_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpz_q    <= 1'b0;
			count_q  <= '0;
			wbank_q  <= 1'b0;
			lead_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				kpz_q <= cfg_write_data;
			end
			valid_s1 <= accept && last_in;
			if (accept) begin
				if (last_in) begin
					count_q <= '0;
					wbank_q <= ~wbank_q;
				end else begin
					if (has_room) begin
						count_q <= count_q + CNT_W'(1);
					end
					lead_q <= lead_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_in) begin
			dec_s1  <= point_position;
			len_s1  <= len_now;
			fmt_s1  <= format_letter;
			neg_s1  <= negative;
			lead_s1 <= lead_now;
			kpz_s1  <= kpz_q;
			bank_s1 <= wbank_q;
		end
	end

	// classify the captured header
	assign dec12   = {dec_s1[10], dec_s1};
	assign len12   = $signed({{(12-CNT_W){1'b0}}, len_s1});
	assign over    = dec12 - len12;
	assign neg_dec = -dec12;
	assign fmt_lc  = fmt_s1 | LETTER_CASE_BIT;
	assign limit   = kpz_s1 ? 12'(TRAIL_LIMIT_KPZ) : 12'(TRAIL_LIMIT);
	assign plain   = (fmt_lc == FMT_G) && (dec12 >= PLAIN_MIN_DEC) && (over <= limit);

	always_comb begin
		if (!lead_s1) begin
			mode = MODE_PASS;
		end else if (!plain) begin
			if (fmt_lc == FMT_R) begin
				mode = MODE_EXP_R;
			end else if (fmt_lc == FMT_N) begin
				mode = MODE_EXP_N;
			end else begin
				mode = MODE_EXP_E;
			end
		end else if (dec12 <= 12'sd0) begin
			mode = MODE_PLAIN_NEG;
		end else if (dec12 < len12) begin
			mode = MODE_PLAIN_MID;
		end else begin
			mode = MODE_PLAIN_INT;
		end
	end

	always_comb begin
		case (mode)
			MODE_EXP_R: e12 = over;
			MODE_EXP_N: e12 = dec12;
			default:    e12 = dec12 - 12'sd1;
		endcase
	end

	assign mag12 = e12[11] ? 12'(-e12) : 12'(e12);
	assign sat10 = (mag12 > EXP_MAX) ? 10'(EXP_MAX) : mag12[9:0];

	always_comb begin
		hund = '0;
		for (int k = 1; k < 10; k++) begin
			if (sat10 >= 10'(k * DEC_HUNDRED)) begin
				hund = 4'(k);
			end
		end
	end

	assign rem10 = sat10 - 10'(hund * DEC_HUNDRED);

	always_comb begin
		push_job          = '0;
		push_job.bank     = bank_s1;
		push_job.len      = len_s1;
		push_job.mode     = mode;
		push_job.neg      = neg_s1;
		push_job.lower    = fmt_s1[5];
		push_job.kpz      = kpz_s1;
		push_job.exp_neg  = e12[11];
		push_job.exp_hund = hund;
		push_job.exp_rem  = rem10[6:0];
		case (mode)
			MODE_EXP_E: begin
				push_job.has_point = len_s1 > CNT_W'(1);
				push_job.point_at  = CNT_W'(1);
			end
			MODE_PLAIN_MID: begin
				push_job.has_point = 1'b1;
				push_job.point_at  = dec_s1[CNT_W-1:0];
			end
			MODE_PLAIN_NEG: push_job.zeros = neg_dec[2:0];
			MODE_PLAIN_INT: push_job.zeros = over[2:0];
			default: push_job.zeros = '0;
		endcase
	end

	assign push = valid_s1;

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
		else $error("header pushed into a full job queue");
`endif

endmodule

### src/ddsf_job_queue.sv
module ddsf_job_queue import ddsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  job_t              push_job,
	input  logic              pop,
	output job_t              head_job,
	output logic [QCNT_W-1:0] count
);

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	assign head_job = entry_q[rd_ptr_q];
	assign count    = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (count_q == QCNT_W'(QUEUE_DEPTH))))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && (count_q == '0)))
		else $error("job queue underflow");
`endif

endmodule

### src/ddsf_back.sv
module ddsf_back import ddsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  buf_wr_t           buf_wr,
	input  job_t              head_job,
	input  logic [QCNT_W-1:0] q_count,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [7:0]        char_out,
	output logic              last_out
);

	logic [7:0] mem_q [2][MAX_DIGITS];

	seq_state_t       state_q;
	seq_state_t       state_d;
	seq_state_t       step_state;
	seq_state_t       body_start;
	seq_state_t       mant_after;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_d;
	logic [2:0]       zcnt_q;
	logic [2:0]       zcnt_d;

	logic             job_ready;
	logic             advance;
	logic             emit;
	logic [CNT_W-1:0] idx_inc;
	logic             mant_done;
	logic [3:0]       tens;
	logic [3:0]       ones;

	logic [7:0] char_d;
	logic       mant_d;
	logic       last_d;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       mant_s1;
	logic       last_s1;
	logic [7:0] rdata_s1;

	assign job_ready = q_count != '0;
	assign advance   = !valid_s1 || !result_stall;
	assign emit      = state_q != ST_IDLE;
	assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
	assign mant_done = idx_inc == head_job.len;

	always_comb begin
		if ((head_job.mode == MODE_EXP_N) || (head_job.mode == MODE_PLAIN_NEG)) begin
			body_start = ST_LEAD_ZERO;
		end else begin
			body_start = ST_MANT;
		end
	end

	always_comb begin
		case (head_job.mode)
			MODE_EXP_R, MODE_EXP_N, MODE_EXP_E: mant_after = ST_EXP_LETTER;
			MODE_PLAIN_INT: begin
				if (head_job.zeros != '0) begin
					mant_after = ST_ZEROS_POST;
				end else if (head_job.kpz) begin
					mant_after = ST_TAIL_POINT;
				end else begin
					mant_after = ST_IDLE;
				end
			end
			default: mant_after = ST_IDLE;
		endcase
	end

	// next state
	always_comb begin
		case (state_q)
			ST_SIGN:       step_state = body_start;
			ST_LEAD_ZERO:  step_state = ST_LEAD_POINT;
			ST_LEAD_POINT: step_state = (zcnt_q != '0) ? ST_ZEROS_PRE : ST_MANT;
			ST_ZEROS_PRE:  step_state = (zcnt_q == 3'd1) ? ST_MANT : ST_ZEROS_PRE;
			ST_MANT: begin
				if (mant_done) begin
					step_state = mant_after;
				end else if (head_job.has_point && (idx_inc == head_job.point_at)) begin
					step_state = ST_MID_POINT;
				end else begin
					step_state = ST_MANT;
				end
			end
			ST_MID_POINT: step_state = ST_MANT;
			ST_ZEROS_POST: begin
				if (zcnt_q != 3'd1) begin
					step_state = ST_ZEROS_POST;
				end else if (head_job.kpz) begin
					step_state = ST_TAIL_POINT;
				end else begin
					step_state = ST_IDLE;
				end
			end
			ST_TAIL_POINT: step_state = ST_TAIL_ZERO;
			ST_EXP_LETTER: step_state = ST_EXP_SIGN;
			ST_EXP_SIGN:   step_state = ST_EXP_D2;
			ST_EXP_D2:     step_state = ST_EXP_D1;
			ST_EXP_D1:     step_state = ST_EXP_D0;
			default:       step_state = ST_IDLE;
		endcase

		state_d = state_q;
		idx_d   = idx_q;
		zcnt_d  = zcnt_q;
		case (state_q)
			ST_IDLE: begin
				if (job_ready) begin
					state_d = head_job.neg ? ST_SIGN : body_start;
					idx_d   = '0;
					zcnt_d  = head_job.zeros;
				end
			end
			default: begin
				if (advance) begin
					state_d = step_state;
					if (state_q == ST_MANT) begin
						idx_d = idx_inc[IDX_W-1:0];
					end
					if ((state_q == ST_ZEROS_PRE) || (state_q == ST_ZEROS_POST)) begin
						zcnt_d = zcnt_q - 3'd1;
					end
				end
			end
		endcase
	end

	always_comb begin
		tens = '0;
		for (int k = 1; k < 10; k++) begin
			if (head_job.exp_rem >= 7'(k * DEC_TEN)) begin
				tens = 4'(k);
			end
		end
	end

	assign ones = 4'(head_job.exp_rem - 7'(tens * DEC_TEN));

	// character of the current step
	always_comb begin
		mant_d = 1'b0;
		last_d = step_state == ST_IDLE;
		case (state_q)
			ST_SIGN:       char_d = CH_MINUS;
			ST_LEAD_ZERO:  char_d = CH_ZERO;
			ST_LEAD_POINT: char_d = CH_POINT;
			ST_ZEROS_PRE:  char_d = CH_ZERO;
			ST_MANT: begin
				char_d = CH_ZERO;
				mant_d = 1'b1;
			end
			ST_MID_POINT:  char_d = CH_POINT;
			ST_ZEROS_POST: char_d = CH_ZERO;
			ST_TAIL_POINT: char_d = CH_POINT;
			ST_TAIL_ZERO:  char_d = CH_ZERO;
			ST_EXP_LETTER: char_d = CH_E_UPPER | (head_job.lower ? LETTER_CASE_BIT : 8'h00);
			ST_EXP_SIGN:   char_d = head_job.exp_neg ? CH_MINUS : CH_PLUS;
			ST_EXP_D2:     char_d = CH_ZERO + 8'(head_job.exp_hund);
			ST_EXP_D1:     char_d = CH_ZERO + 8'(tens);
			ST_EXP_D0:     char_d = CH_ZERO + 8'(ones);
			default:       char_d = CH_ZERO;
		endcase
	end

	// release the bank once its final character moves to the output register
	assign pop = emit && advance && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			zcnt_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			zcnt_q  <= zcnt_d;
			if (advance) begin
				valid_s1 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem_q[buf_wr.bank][buf_wr.addr] <= buf_wr.data;
		end
		if (advance && emit) begin
			rdata_s1 <= mem_q[head_job.bank][idx_q];
			char_s1  <= char_d;
			mant_s1  <= mant_d;
			last_s1  <= last_d;
		end
	end

	assign result_valid = valid_s1;
	assign char_out     = mant_s1 ? rdata_s1 : char_s1;
	assign last_out     = last_s1;

`ifndef SYNTHESIS
	a_busy_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (q_count != '0))
		else $error("sequencer running without a queued job");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MANT) |-> (CNT_W'(idx_q) < head_job.len))
		else $error("mantissa index past buffered length");
	a_pop_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_IDLE))
		else $error("job released while still printing");
`endif

endmodule

### src/decimal_digit_string_formatter.sv
// Decimal digit string formatter.
// Input channel (item_valid / item_stall): one mantissa character per transfer.
// The transfer with last_in high also carries negative, point_position and
// format_letter; those header fields are ignored on other transfers.
// Output channel (result_valid / result_stall): one text character per
// transfer, last_out high on the final character of a number.
// Configuration: cfg_write_en writes keep_point_zero from cfg_write_data.
// With the output side idle, result_valid rises once the header of the last
// mantissa character has passed the header register, the job queue, the
// sequencer's per-number load step in ST_IDLE and the output register;
// characters then follow one per cycle while the receiver takes them.
// Throughput: one mantissa character per cycle while item_stall is low;
// when sustained, loading one number overlaps printing the previous one.
// Two buffer banks let the next number load while the previous prints; the
// input stalls when both banks hold numbers not yet fully printed.
// A receiver stall holds the output character and freezes a running sequencer.
// Reset empties both banks, clears the job queue and keep_point_zero.
module decimal_digit_string_formatter import ddsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [7:0]         char_in,
	input  logic               last_in,
	input  logic               negative,
	input  logic signed [10:0] point_position,
	input  logic [7:0]         format_letter,
	input  logic               cfg_write_en,
	input  logic               cfg_write_data,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         char_out,
	output logic               last_out
);

	logic              push;
	logic              pop;
	job_t              push_job;
	job_t              head_job;
	logic [QCNT_W-1:0] q_count;
	buf_wr_t           buf_wr;

	ddsf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.char_in        (char_in),
		.last_in        (last_in),
		.negative       (negative),
		.point_position (point_position),
		.format_letter  (format_letter),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.q_count        (q_count),
		.push           (push),
		.push_job       (push_job),
		.buf_wr         (buf_wr)
	);

	ddsf_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.count    (q_count)
	);

	ddsf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.buf_wr       (buf_wr),
		.head_job     (head_job),
		.q_count      (q_count),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.char_out     (char_out),
		.last_out     (last_out)
	);

endmodule

### verif/decimal_digit_string_formatter_tb.sv
module decimal_digit_string_formatter_tb import ddsf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] FMT_E         = 8'h65;
	localparam logic [7:0] FMT_ANY_LOW   = 8'h00;
	localparam logic [7:0] FMT_ANY_HIGH  = 8'hFF;
	localparam int         IDLE_PCT      = 31;
	localparam int         SETTLE_CYCLES = 10;
	localparam int         PHASE_ITEMS   = 35;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic [7:0]         char_in;
	logic               last_in;
	logic               negative;
	logic signed [10:0] point_position;
	logic [7:0]         format_letter;
	logic               cfg_write_en;
	logic               cfg_write_data;
	logic               result_valid;
	logic               result_stall;
	logic [7:0]         char_out;
	logic               last_out;

	// formatter model state
	logic [7:0] mant_chars [MAX_DIGITS];
	int         mant_count;
	logic       kpz_setting;
	text_char_t pending_text [$];

	bit calm;
	int failures;
	int items_sent;
	int numbers_sent;
	int chars_checked;

	decimal_digit_string_formatter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.char_in        (char_in),
		.last_in        (last_in),
		.negative       (negative),
		.point_position (point_position),
		.format_letter  (format_letter),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.char_out       (char_out),
		.last_out       (last_out)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("decimal_digit_string_formatter_tb: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_text.size() == 0) begin
				$error("char_out: no character expected, got %h", char_out);
				failures++;
			end else begin
				want = pending_text.pop_front();
				if (char_out !== want.ch) begin
					$error("char_out: expected %h, got %h", want.ch, char_out);
					failures++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %b, got %b", want.last, last_out);
					failures++;
				end
				chars_checked++;
			end
		end
	end

	task automatic predict_text(input logic neg, input logic signed [10:0] pos,
			input logic [7:0] fmt);
		logic [7:0] txt [$];
		logic [7:0] sel;
		int len;
		int dec;
		int mag;
		int trail;
		len = mant_count;
		mant_count = 0;
		dec = int'(pos);
		sel = fmt | LETTER_CASE_BIT;
		trail = kpz_setting ? TRAIL_LIMIT_KPZ : TRAIL_LIMIT;
		if (neg)
			txt.push_back(CH_MINUS);
		if (mant_chars[0] < CH_ZERO || mant_chars[0] > CH_NINE) begin
			// Inf, NaN and other text pass through
			for (int i = 0; i < len; i++)
				txt.push_back(mant_chars[i]);
		end else if (sel != FMT_G || dec < PLAIN_MIN_DEC || dec - len > trail) begin
			if (sel == FMT_R) begin
				dec -= len;
				for (int i = 0; i < len; i++)
					txt.push_back(mant_chars[i]);
			end else if (sel == FMT_N) begin
				txt.push_back(CH_ZERO);
				txt.push_back(CH_POINT);
				for (int i = 0; i < len; i++)
					txt.push_back(mant_chars[i]);
			end else begin
				dec--;
				txt.push_back(mant_chars[0]);
				if (len > 1)
					txt.push_back(CH_POINT);
				for (int i = 1; i < len; i++)
					txt.push_back(mant_chars[i]);
			end
			txt.push_back(CH_E_UPPER | (fmt & LETTER_CASE_BIT));
			txt.push_back(dec < 0 ? CH_MINUS : CH_PLUS);
			mag = dec < 0 ? -dec : dec;
			if (mag > EXP_MAX)
				mag = EXP_MAX;
			txt.push_back(8'(CH_ZERO + mag / DEC_HUNDRED));
			txt.push_back(8'(CH_ZERO + (mag / DEC_TEN) % DEC_TEN));
			txt.push_back(8'(CH_ZERO + mag % DEC_TEN));
		end else if (dec <= 0) begin
			txt.push_back(CH_ZERO);
			txt.push_back(CH_POINT);
			for (int i = dec; i < 0; i++)
				txt.push_back(CH_ZERO);
			for (int i = 0; i < len; i++)
				txt.push_back(mant_chars[i]);
		end else if (dec < len) begin
			for (int i = 0; i < len; i++) begin
				if (i == dec)
					txt.push_back(CH_POINT);
				txt.push_back(mant_chars[i]);
			end
		end else begin
			for (int i = 0; i < len; i++)
				txt.push_back(mant_chars[i]);
			for (int i = len; i < dec; i++)
				txt.push_back(CH_ZERO);
			if (kpz_setting) begin
				txt.push_back(CH_POINT);
				txt.push_back(CH_ZERO);
			end
		end
		foreach (txt[i])
			pending_text.push_back('{ch: txt[i], last: (i == txt.size() - 1)});
		numbers_sent++;
	endtask

	// Header fields only count on the last character; drive junk elsewhere.
	task automatic send_char(input logic [7:0] ch, input logic last, input logic neg,
			input logic signed [10:0] pos, input logic [7:0] fmt);
		item_valid     <= 1'b1;
		char_in        <= ch;
		last_in        <= last;
		negative       <= last ? neg : 1'($urandom_range(0, 1));
		point_position <= last ? pos : 11'($urandom_range(0, 1998) - 999);
		format_letter  <= last ? fmt : 8'($urandom_range(0, 255));
		do
			@(posedge clk);
		while (item_stall);
		if (mant_count < MAX_DIGITS) begin
			mant_chars[mant_count] = ch;
			mant_count++;
		end
		items_sent++;
		if (last)
			predict_text(neg, pos, fmt);
		// idle cycle by cycle
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_number(input string mant, input logic neg,
			input logic signed [10:0] pos, input logic [7:0] fmt);
		for (int i = 0; i < mant.len(); i++)
			send_char(mant[i], i == mant.len() - 1, neg, pos, fmt);
	endtask

	task automatic wait_idle();
		if (item_valid)
			item_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_keep_point_zero(input logic value);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		kpz_setting = value;
	endtask

	task automatic test_directed_formats();
		send_number("5", 1'b0, 11'sd0, FMT_E);
		send_number("12", 1'b1, -11'sd999, FMT_R);
		send_number("9", 1'b1, 11'sd999, FMT_N);
		send_number("12", 1'b0, -11'sd999, FMT_R & ~LETTER_CASE_BIT);
		send_number("314", 1'b0, -11'sd999, FMT_E);
		send_number("Inf", 1'b1, 11'sd3, FMT_G);
		// non-digit lead at the byte extremes
		send_char(8'hFF, 1'b0, 1'b0, 11'sd0, FMT_G);
		send_char(8'h00, 1'b1, 1'b0, 11'sd1, FMT_G);
		send_number("123", 1'b0, 11'sd1, FMT_G);
		send_number("5", 1'b0, -11'sd3, FMT_G);
		send_number("5", 1'b1, -11'sd4, FMT_G);
		send_number("5", 1'b0, 11'sd6, FMT_G & ~LETTER_CASE_BIT);
		send_number("5", 1'b0, 11'sd7, FMT_G);
		send_number("7", 1'b0, 11'sd0, FMT_ANY_LOW);
		send_number("7", 1'b1, 11'sd0, FMT_ANY_HIGH);
		send_number("1", 1'b0, 11'sd0, FMT_G);
		wait_idle();
	endtask

	task automatic test_keep_point_zero();
		write_keep_point_zero(1'b1);
		send_number("5", 1'b0, 11'sd1, FMT_G);
		send_number("25", 1'b1, 11'sd5, FMT_G);
		send_number("5", 1'b0, 11'sd5, FMT_G);
		send_number("12", 1'b0, 11'sd1, FMT_G);
		wait_idle();
	endtask

	task automatic send_random_number(input bit overflow);
		int len;
		int kind;
		int sel;
		int r;
		string word;
		logic [7:0] ch;
		logic [7:0] fmt;
		logic signed [10:0] pos;
		logic neg;
		r = $urandom_range(0, 99);
		if (overflow)
			len = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
		else if (r < 70)
			len = $urandom_range(1, 6);
		else
			len = $urandom_range(7, MAX_DIGITS);
		kind = $urandom_range(0, 99);
		word = $urandom_range(0, 1) ? "Inf" : "NaN";
		if (kind >= 75 && kind < 85)
			len = word.len();
		sel = $urandom_range(0, 11);
		if (sel < 2)
			fmt = FMT_N;
		else if (sel < 4)
			fmt = FMT_E;
		else if (sel < 6)
			fmt = FMT_R;
		else if (sel < 10)
			fmt = FMT_G;
		else
			fmt = 8'($urandom_range(0, 255));
		if (sel < 10 && $urandom_range(0, 1))
			fmt = fmt & ~LETTER_CASE_BIT;
		r = $urandom_range(0, 99);
		// keep most positions near the shortest-form boundaries
		if (r < 60)
			pos = 11'($urandom_range(0, len + 12) - 5);
		else if (r < 75)
			pos = $urandom_range(0, 1) ? 11'sd999 : -11'sd999;
		else
			pos = 11'($urandom_range(0, 1998) - 999);
		neg = 1'($urandom_range(0, 1));
		for (int i = 0; i < len; i++) begin
			if (kind < 75)
				ch = 8'(CH_ZERO + $urandom_range(0, 9));
			else if (kind < 85)
				ch = word[i];
			else
				ch = 8'($urandom_range(0, 255));
			send_char(ch, i == len - 1, neg, pos, fmt);
		end
	endtask

	task automatic test_random_numbers();
		logic kpz_by_phase [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
		int phase_end;
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_keep_point_zero(kpz_by_phase[p]);
			calm = (p == 2);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_random_number(numbers_sent % 10 == 9);
		end
		wait_idle();
		calm = 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		char_in        = '0;
		last_in        = 1'b0;
		negative       = 1'b0;
		point_position = '0;
		format_letter  = '0;
		cfg_write_en   = 1'b0;
		cfg_write_data = 1'b0;
		result_stall   = 1'b0;
		kpz_setting    = 1'b0;
		mant_count     = 0;
		calm           = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_formats();
		test_keep_point_zero();
		test_random_numbers();
		$display("Covered %0d numbers from %0d mantissa transfers, %0d output characters,",
			numbers_sent, items_sent, chars_checked);
		$display("all formats, Inf/NaN and noise text, overflow, both keep_point_zero values.");
		if (failures == 0 && pending_text.size() == 0)
			$display("decimal_digit_string_formatter_tb: PASS");
		else
			$display("decimal_digit_string_formatter_tb: FAIL");
		$finish;
	end

endmodule
